[design/snlp_pkg.sv]
// Package for the sized number literal parser.
// Holds widths, character and radix codes, the parse phase type, the
// digit accumulator state struct and the radix code function; no dependencies.
package snlp_pkg;

  localparam int VALUE_BITS = 64;
  localparam int WIDTH_BITS = 16;
  localparam int CH_BITS    = 8;

  localparam logic [1:0] RC_BIN = 2'd0;
  localparam logic [1:0] RC_OCT = 2'd1;
  localparam logic [1:0] RC_DEC = 2'd2;
  localparam logic [1:0] RC_HEX = 2'd3;

  localparam logic [CH_BITS-1:0] CH_TICK  = 8'h27;
  localparam logic [CH_BITS-1:0] CH_UNDER = 8'h5F;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_LS    = 8'h73;
  localparam logic [CH_BITS-1:0] CH_US    = 8'h53;
  localparam logic [CH_BITS-1:0] CH_B     = 8'h62;
  localparam logic [CH_BITS-1:0] CH_O     = 8'h6F;
  localparam logic [CH_BITS-1:0] CH_D     = 8'h64;
  localparam logic [CH_BITS-1:0] CH_H     = 8'h68;
  localparam logic [CH_BITS-1:0] CH_X     = 8'h78;

  typedef enum logic [3:0] {
    PH_BEFORE = 4'b0001,
    PH_TICK   = 4'b0010,
    PH_SIGN   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  sat;
    logic                  done;
  } digit_st_t;

  function automatic logic [1:0] radix_code_f(input logic [CH_BITS-1:0] b);
    logic [1:0] rc;
    if (b == CH_B) rc = RC_BIN;
    else if (b == CH_O) rc = RC_OCT;
    else if (b == CH_H || b == CH_X) rc = RC_HEX;
    else rc = RC_DEC;
    return rc;
  endfunction

endpackage

[design/sized_number_literal_parser.sv]
// Sized number literal parser, top level: input register, combinational parse
// step, result register. Depends on snlp_pkg and snlp_digit.
// Throughput: one character word per cycle; a last word stalls while the result
// register is full and out_ready is low. The accumulate (value times radix plus
// digit, overflow compare) is combinational; out_valid is the result register.
// Reset (rst_n low, synchronous): parse state back to start, both stages emptied.
module sized_number_literal_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [snlp_pkg::CH_BITS-1:0]       in_ch,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [snlp_pkg::VALUE_BITS-1:0]    out_value,
  output logic [snlp_pkg::WIDTH_BITS-1:0]    out_declared_width,
  output logic [snlp_pkg::CH_BITS-1:0]       out_base_char,
  output logic [1:0]                         out_radix_code,
  output logic                               out_is_signed,
  output logic                               out_overflowed,
  output logic                               out_had_tick
);
  import snlp_pkg::*;

  localparam logic [1:0] CI_FIRST  = 2'd0;
  localparam logic [1:0] CI_SECOND = 2'd1;
  localparam logic [1:0] CI_REST   = 2'd2;
  localparam int WEXT_BITS = WIDTH_BITS + 4;

  // input stage
  logic                  in_v_r;
  logic [CH_BITS-1:0]    ch_r;
  logic                  last_r;

  // parse state
  phase_t                phase_r, phase_nxt;
  logic [1:0]            cidx_r, cidx_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [WIDTH_BITS-1:0] width_r, width_nxt;
  logic                  wdone_r, wdone_nxt;
  logic                  done_r, done_nxt;
  logic [CH_BITS-1:0]    base_r, base_nxt;
  logic                  signed_r, signed_nxt;
  logic                  sat_r, sat_nxt;
  logic                  tick_r, tick_nxt;

  // result stage
  logic                  out_v_r;
  logic [VALUE_BITS-1:0] o_value_r;
  logic [WIDTH_BITS-1:0] o_width_r;
  logic [CH_BITS-1:0]    o_base_r;
  logic [1:0]            o_rc_r;
  logic                  o_signed_r;
  logic                  o_ovf_r;
  logic                  o_tick_r;

  logic                  advance;
  logic                  emit;
  digit_st_t             ds_cur;
  digit_st_t             ds_nxt;
  logic [WEXT_BITS-1:0]  wext;
  logic [WEXT_BITS-1:0]  wsum;

  assign advance  = in_v_r && (!last_r || !out_v_r || out_ready);
  assign emit     = advance && last_r;
  assign in_ready = !in_v_r || advance;

  assign ds_cur = '{value: value_r, sat: sat_r, done: done_r};

  snlp_digit u_digit (
    .cur   (ds_cur),
    .radix (radix_code_f(base_r)),
    .ch    (ch_r),
    .nxt   (ds_nxt)
  );

  always_comb begin
    wext = {4'b0, width_r};
    wsum = (wext << 3) + (wext << 1) + WEXT_BITS'(ch_r[3:0]);

    phase_nxt  = phase_r;
    cidx_nxt   = cidx_r;
    value_nxt  = value_r;
    width_nxt  = width_r;
    wdone_nxt  = wdone_r;
    done_nxt   = done_r;
    base_nxt   = base_r;
    signed_nxt = signed_r;
    sat_nxt    = sat_r;
    tick_nxt   = tick_r;

    case (phase_r)
      PH_BEFORE: begin
        if (ch_r == CH_TICK) begin
          tick_nxt  = 1'b1;
          phase_nxt = PH_TICK;
          value_nxt = '0;
          sat_nxt   = 1'b0;
          done_nxt  = 1'b0;
          base_nxt  = '0;
        end else begin
          if (!wdone_r) begin
            if (ch_r >= CH_ZERO && ch_r <= CH_NINE) begin
              width_nxt = (|wsum[WEXT_BITS-1:WIDTH_BITS]) ? '1 : wsum[WIDTH_BITS-1:0];
            end else begin
              wdone_nxt = 1'b1;
            end
          end
          case (cidx_r)
            CI_FIRST: begin
              cidx_nxt  = (ch_r == CH_ZERO) ? CI_SECOND : CI_REST;
              value_nxt = ds_nxt.value;
              sat_nxt   = ds_nxt.sat;
              done_nxt  = ds_nxt.done;
            end
            CI_SECOND: begin
              cidx_nxt = CI_REST;
              if (ch_r == CH_X) begin
                base_nxt  = CH_X;
                value_nxt = '0;
              end else begin
                value_nxt = ds_nxt.value;
                sat_nxt   = ds_nxt.sat;
                done_nxt  = ds_nxt.done;
              end
            end
            default: begin
              value_nxt = ds_nxt.value;
              sat_nxt   = ds_nxt.sat;
              done_nxt  = ds_nxt.done;
            end
          endcase
        end
      end
      PH_TICK: begin
        if (ch_r == CH_LS || ch_r == CH_US) begin
          signed_nxt = 1'b1;
          phase_nxt  = PH_SIGN;
        end else begin
          base_nxt  = ch_r;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_SIGN: begin
        base_nxt  = ch_r;
        phase_nxt = PH_DIGITS;
      end
      PH_DIGITS: begin
        value_nxt = ds_nxt.value;
        sat_nxt   = ds_nxt.sat;
        done_nxt  = ds_nxt.done;
      end
      default: begin
        phase_nxt = PH_BEFORE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      phase_r  <= PH_BEFORE;
      cidx_r   <= CI_FIRST;
      value_r  <= '0;
      width_r  <= '0;
      wdone_r  <= 1'b0;
      done_r   <= 1'b0;
      base_r   <= CH_D;
      signed_r <= 1'b0;
      sat_r    <= 1'b0;
      tick_r   <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      cidx_r   <= cidx_nxt;
      value_r  <= value_nxt;
      width_r  <= width_nxt;
      wdone_r  <= wdone_nxt;
      done_r   <= done_nxt;
      base_r   <= base_nxt;
      signed_r <= signed_nxt;
      sat_r    <= sat_nxt;
      tick_r   <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
    if (emit) begin
      o_value_r  <= value_nxt;
      o_width_r  <= tick_nxt ? width_nxt : '0;
      o_base_r   <= base_nxt;
      o_rc_r     <= radix_code_f(base_nxt);
      o_signed_r <= signed_nxt;
      o_ovf_r    <= sat_nxt;
      o_tick_r   <= tick_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_value          = o_value_r;
  assign out_declared_width = o_width_r;
  assign out_base_char      = o_base_r;
  assign out_radix_code     = o_rc_r;
  assign out_is_signed      = o_signed_r;
  assign out_overflowed     = o_ovf_r;
  assign out_had_tick       = o_tick_r;

  a_ovf_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> &out_value)
    else $error("overflowed word without saturated value");

  a_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_had_tick |-> out_declared_width == '0 && !out_is_signed)
    else $error("width or sign reported without tick");

  a_phase_tick: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_BEFORE |-> tick_r)
    else $error("past-tick phase without tick seen");

  a_hex_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BEFORE && base_r == CH_X |-> cidx_r == CI_REST)
    else $error("hex prefix state inconsistent");

endmodule

[design/snlp_digit.sv]
// Digit accumulator step: folds one character into the value register
// contents, with underscore skip, end-of-digits detect and saturation.
// Depends on snlp_pkg.
module snlp_digit (
  input  snlp_pkg::digit_st_t                cur,
  input  logic [1:0]                         radix,
  input  logic [snlp_pkg::CH_BITS-1:0]       ch,
  output snlp_pkg::digit_st_t                nxt
);
  import snlp_pkg::*;

  localparam int EXT_BITS = VALUE_BITS + 4;

  logic [5:0]          dval;
  logic                alnum;
  logic [4:0]          rnum;
  logic                d_ok;
  logic [EXT_BITS-1:0] ext;
  logic [EXT_BITS-1:0] prod;
  logic [EXT_BITS-1:0] sum;

  always_comb begin
    alnum = 1'b1;
    dval  = 6'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      dval = 6'(ch - CH_ZERO);
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      dval = 6'(ch - CH_LA) + 6'd10;
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      dval = 6'(ch - CH_UA) + 6'd10;
    end else begin
      alnum = 1'b0;
    end

    ext = {4'b0, cur.value};
    case (radix)
      RC_BIN: begin
        rnum = 5'd2;
        prod = ext << 1;
      end
      RC_OCT: begin
        rnum = 5'd8;
        prod = ext << 3;
      end
      RC_HEX: begin
        rnum = 5'd16;
        prod = ext << 4;
      end
      default: begin
        rnum = 5'd10;
        prod = (ext << 3) + (ext << 1);
      end
    endcase

    d_ok = alnum && (dval < 6'(rnum));
    sum  = prod + EXT_BITS'(dval[3:0]);

    nxt = cur;
    if (!cur.done && ch != CH_UNDER) begin
      if (!d_ok) begin
        nxt.done = 1'b1;
      end else if (!cur.sat) begin
        if (|sum[EXT_BITS-1:VALUE_BITS]) begin
          nxt.value = '1;
          nxt.sat   = 1'b1;
        end else begin
          nxt.value = sum[VALUE_BITS-1:0];
        end
      end
    end
  end

endmodule
